FILE: hw/rtl/acmm_pkg.sv
// Shared types and codes of the channel mixing matrix.
`default_nettype none

package acmm_pkg;

    // Request codes on the request channel.
    localparam logic [1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [1:0] REQ_COEF     = 2'd1;
    localparam logic [1:0] REQ_IDENTITY = 2'd2;

    // Configuration register indexes, port widths and the reset count.
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0]  CFG_IN_CHANNELS  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0]  CFG_OUT_CHANNELS = 4'd1;
    localparam logic [CFG_DATA_BITS-1:0] CFG_RESET_COUNT  = 4'd2;

    // Microprogram step addresses.
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_READ   = 3'd1;
    localparam step_t STEP_MUL    = 3'd2;
    localparam step_t STEP_ACC    = 3'd3;
    localparam step_t STEP_ROUND  = 3'd4;
    localparam step_t STEP_EMIT   = 3'd5;
    localparam step_t STEP_ROWCHK = 3'd6;
    localparam step_t STEP_LOOP   = 3'd7;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_ROUND
    } acc_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_START,
        COND_COL_MORE,
        COND_OUT_BUSY,
        COND_ROWS_DONE,
        COND_ALWAYS
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic    in_ready;
        logic    rd_en;
        logic    mul_en;
        acc_op_t acc_op;
        logic    clr_idx;
        logic    col_inc;
        logic    emit;
        cond_t   cond;
        step_t   target;
    } acmm_ctrl_t;

    // Datapath flags tested by the jump conditions.
    typedef struct packed {
        logic start;
        logic col_more;
        logic rows_done;
        logic out_busy;
    } acmm_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/acmm_if.sv
// Request, result and configuration channel interfaces of the mixing matrix.
`default_nettype none

interface acmm_req_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [2:0]                    coef_in_channel;
    logic [2:0]                    coef_out_channel;
    logic signed [COEF_BITS-1:0]   coef_value;

    modport source (
        output valid, req_type, sample, coef_in_channel, coef_out_channel, coef_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, sample, coef_in_channel, coef_out_channel, coef_value,
        output ready
    );
endinterface

interface acmm_res_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mixed_sample;
    logic [2:0]                    out_channel;
    logic                          frame_last;

    modport source (
        output valid, mixed_sample, out_channel, frame_last,
        input  ready
    );
    modport sink (
        input  valid, mixed_sample, out_channel, frame_last,
        output ready
    );
endinterface

interface acmm_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [3:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/acmm_ucode_rom.sv
// Microprogram store: one control word per step of the mixing loop.
`default_nettype none

module acmm_ucode_rom import acmm_pkg::*; (
    input  step_t      step,
    output acmm_ctrl_t ctrl
);

    always_comb
    begin
        ctrl        = '0;
        ctrl.acc_op = ACC_HOLD;
        ctrl.cond   = COND_NEVER;
        ctrl.target = STEP_IDLE;
        case (step)
            STEP_IDLE:
            begin
                // take requests; leave only when a sample closes a frame
                ctrl.in_ready = 1'b1;
                ctrl.acc_op   = ACC_CLEAR;
                ctrl.clr_idx  = 1'b1;
                ctrl.cond     = COND_NO_START;
                ctrl.target   = STEP_IDLE;
            end
            STEP_READ:
            begin
                ctrl.rd_en = 1'b1;
            end
            STEP_MUL:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.col_inc = 1'b1;
            end
            STEP_ACC:
            begin
                ctrl.acc_op = ACC_ADD;
                ctrl.cond   = COND_COL_MORE;
                ctrl.target = STEP_READ;
            end
            STEP_ROUND:
            begin
                ctrl.acc_op = ACC_ROUND;
            end
            STEP_EMIT:
            begin
                // hold here while the result register is full and res is not ready
                ctrl.emit   = 1'b1;
                ctrl.cond   = COND_OUT_BUSY;
                ctrl.target = STEP_EMIT;
            end
            STEP_ROWCHK:
            begin
                ctrl.cond   = COND_ROWS_DONE;
                ctrl.target = STEP_IDLE;
            end
            STEP_LOOP:
            begin
                ctrl.cond   = COND_ALWAYS;
                ctrl.target = STEP_READ;
            end
            default:
            begin
                ctrl.cond   = COND_ALWAYS;
                ctrl.target = STEP_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/acmm_seq.sv
// Step counter with conditional jumps over the microprogram store.
`default_nettype none

module acmm_seq import acmm_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  acmm_status_t status,
    output acmm_ctrl_t   ctrl,
    output step_t        step
);

    step_t step_reg;
    step_t step_next;
    logic  jump;

    acmm_ucode_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     jump = 1'b0;
            COND_NO_START:  jump = !status.start;
            COND_COL_MORE:  jump = status.col_more;
            COND_OUT_BUSY:  jump = status.out_busy;
            COND_ROWS_DONE: jump = status.rows_done;
            COND_ALWAYS:    jump = 1'b1;
            default:        jump = 1'b1;
        endcase
        step_next = jump ? ctrl.target : step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/acmm_datapath.sv
// Frame store, coefficient memory, shared multiply-accumulate and result register.
`default_nettype none

module acmm_datapath import acmm_pkg::*; #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int COEF_BITS    = 16,
    localparam int CNTW        = $clog2(MAX_CHANNELS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  acmm_ctrl_t      ctrl,
    input  logic [CNTW-1:0] nin,
    input  logic [CNTW-1:0] nout,
    output acmm_status_t    status,
    acmm_req_if.sink        req,
    acmm_res_if.source      res
);

    localparam int IW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PW     = SAMPLE_BITS + COEF_BITS;
    localparam int AW     = SAMPLE_BITS + COEF_BITS + IW + 2;
    localparam int FRAC   = COEF_BITS - 2;
    localparam int DEPTH  = 2 ** (2 * IW);
    localparam bit SAT_EN = (AW > 63);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << FRAC);
    localparam logic signed [AW-1:0] HALF_W   = AW'(1) << (FRAC - 1);
    localparam logic signed [AW-1:0] ACC_HI_W = AW'(64'sh3FFF_FFFF_FFFF_FFFF);
    localparam logic signed [AW-1:0] ACC_LO_W = AW'(64'shC000_0000_0000_0000);
    localparam logic signed [AW-1:0] SMAX_W   =
        {{(AW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN_W   =
        {{(AW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMAX_S = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN_S = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] frame_mem [MAX_CHANNELS];
    logic signed [COEF_BITS-1:0]   coef_mem  [DEPTH];

    logic [DEPTH-1:0]              coef_vld_reg, coef_vld_next;
    logic [IW-1:0]                 pos_reg, pos_next;
    logic [CNTW-1:0]               row_reg, row_next;
    logic [CNTW-1:0]               col_reg, col_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [COEF_BITS-1:0]   coef_rd_reg;
    logic                          vld_rd_reg;
    logic                          diag_rd_reg;
    logic signed [SAMPLE_BITS-1:0] samp_rd_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [AW-1:0]          acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [2:0]                    out_chan_reg;
    logic                          out_last_reg;

    logic                          in_fire;
    logic                          sample_wr;
    logic                          coef_wr;
    logic                          frame_end;
    logic                          emit_fire;
    logic [2*IW-1:0]               wr_addr;
    logic [2*IW-1:0]               rd_addr;
    logic signed [COEF_BITS-1:0]   coef_eff;
    logic signed [PW-1:0]          prod;
    logic signed [AW-1:0]          sum;
    logic signed [AW-1:0]          sum_sat;
    logic signed [AW-1:0]          rnd;
    logic signed [SAMPLE_BITS-1:0] rnd_sat;

    assign req.ready = ctrl.in_ready;
    assign in_fire   = req.valid && ctrl.in_ready;
    assign sample_wr = in_fire && (req.req_type == REQ_SAMPLE);
    assign coef_wr   = in_fire && (req.req_type == REQ_COEF)
                       && (int'(req.coef_in_channel) < MAX_CHANNELS)
                       && (int'(req.coef_out_channel) < MAX_CHANNELS);
    assign frame_end = (CNTW'(pos_reg) + CNTW'(1)) >= nin;
    assign emit_fire = ctrl.emit && !status.out_busy;

    assign wr_addr = {IW'(req.coef_out_channel), IW'(req.coef_in_channel)};
    assign rd_addr = {row_reg[IW-1:0], col_reg[IW-1:0]};

    assign status.start     = sample_wr && frame_end;
    assign status.col_more  = col_reg < nin;
    assign status.rows_done = row_reg >= nout;
    assign status.out_busy  = out_valid_reg && !res.ready;

    // entries never written since reset or the last identity request read as identity
    assign coef_eff = vld_rd_reg ? coef_rd_reg : (diag_rd_reg ? COEF_ONE : '0);
    assign prod     = samp_rd_reg * coef_eff;

    always_comb
    begin
        sum     = acc_reg + AW'(prod_reg);
        sum_sat = sum;
        if (SAT_EN && (sum > ACC_HI_W))
        begin
            sum_sat = ACC_HI_W;
        end
        else if (SAT_EN && (sum < ACC_LO_W))
        begin
            sum_sat = ACC_LO_W;
        end

        rnd = acc_reg >>> FRAC;
        if (rnd > SMAX_W)
        begin
            rnd_sat = SMAX_S;
        end
        else if (rnd < SMIN_W)
        begin
            rnd_sat = SMIN_S;
        end
        else
        begin
            rnd_sat = SAMPLE_BITS'(rnd);
        end

        case (ctrl.acc_op)
            ACC_HOLD:  acc_next = acc_reg;
            ACC_CLEAR: acc_next = '0;
            ACC_ADD:   acc_next = sum_sat;
            ACC_ROUND: acc_next = acc_reg + HALF_W;
            default:   acc_next = acc_reg;
        endcase
        if (emit_fire)
        begin
            acc_next = '0;
        end
    end

    always_comb
    begin
        coef_vld_next = coef_vld_reg;
        if (in_fire && (req.req_type == REQ_IDENTITY))
        begin
            coef_vld_next = '0;
        end
        else if (coef_wr)
        begin
            coef_vld_next[wr_addr] = 1'b1;
        end

        pos_next = pos_reg;
        if (sample_wr)
        begin
            pos_next = frame_end ? '0 : pos_reg + IW'(1);
        end

        row_next = row_reg;
        col_next = col_reg;
        if (ctrl.clr_idx)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (emit_fire)
        begin
            row_next = row_reg + CNTW'(1);
            col_next = '0;
        end
        else if (ctrl.col_inc)
        begin
            col_next = col_reg + CNTW'(1);
        end

        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg  <= '0;
            pos_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            coef_vld_reg  <= coef_vld_next;
            pos_reg       <= pos_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[wr_addr] <= req.coef_value;
        end
        if (ctrl.rd_en)
        begin
            coef_rd_reg <= coef_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_wr)
        begin
            frame_mem[pos_reg] <= req.sample;
        end
        if (ctrl.rd_en)
        begin
            samp_rd_reg <= frame_mem[col_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            vld_rd_reg  <= coef_vld_reg[rd_addr];
            diag_rd_reg <= (row_reg == col_reg);
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod;
        end
        acc_reg <= acc_next;
        if (emit_fire)
        begin
            out_sample_reg <= rnd_sat;
            out_chan_reg   <= 3'(row_reg);
            out_last_reg   <= (row_reg + CNTW'(1)) == nout;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.mixed_sample = out_sample_reg;
    assign res.out_channel  = out_chan_reg;
    assign res.frame_last   = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/audio_channel_matrix_mixer.sv
// Top level of the channel mixing matrix: configuration registers, sequencer and datapath.
`default_nettype none

// Channel mixing matrix. Interleaved samples arrive on req one channel at a time
// (req_type sample); coefficient writes and identity requests share the channel.
// Requests are taken in the idle step; the sample that closes a frame starts
// the microprogram, which runs all products through one shared multiplier, one
// input channel at a time through three steps (read, multiply, accumulate), then
// rounds, emits, checks the row and loops back; req stays not ready until the
// last row has been emitted, and a stall on res holds the emit step. Results
// come out in output channel order through a result register, so the last one
// of a frame may still wait on res while new requests are taken. The coefficient
// memory reads as identity after reset until entries are written; an identity
// request restores it by clearing the valid bits, and there is no clearing pass.
// Register counts of 0 act as 1 and counts above MAX_CHANNELS as MAX_CHANNELS;
// the cfg port is always ready.
module audio_channel_matrix_mixer import acmm_pkg::*; #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int COEF_BITS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    acmm_req_if.sink   req,
    acmm_res_if.source res,
    acmm_cfg_if.sink   cfg
);

    localparam int CNTW = $clog2(MAX_CHANNELS + 1);

    logic [CFG_DATA_BITS-1:0] in_ch_reg, in_ch_next;
    logic [CFG_DATA_BITS-1:0] out_ch_reg, out_ch_next;
    logic [CNTW-1:0]          nin;
    logic [CNTW-1:0]          nout;
    acmm_ctrl_t               ctrl;
    acmm_status_t             status;
    step_t                    step;

    function automatic logic [CNTW-1:0] eff_count(input logic [CFG_DATA_BITS-1:0] v);
        logic [CNTW-1:0] r;
        if (v == '0)
        begin
            r = CNTW'(1);
        end
        else if (int'(v) > MAX_CHANNELS)
        begin
            r = CNTW'(MAX_CHANNELS);
        end
        else
        begin
            r = CNTW'(v);
        end
        return r;
    endfunction

    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_ch_next  = in_ch_reg;
        out_ch_next = out_ch_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_IN_CHANNELS:  in_ch_next  = cfg.data;
                CFG_OUT_CHANNELS: out_ch_next = cfg.data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg  <= CFG_RESET_COUNT;
            out_ch_reg <= CFG_RESET_COUNT;
        end
        else
        begin
            in_ch_reg  <= in_ch_next;
            out_ch_reg <= out_ch_next;
        end
    end

    assign nin  = eff_count(in_ch_reg);
    assign nout = eff_count(out_ch_reg);

    acmm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .step   (step)
    );

    acmm_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEF_BITS    (COEF_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .nin    (nin),
        .nout   (nout),
        .status (status),
        .req    (req),
        .res    (res)
    );

`ifndef NO_ASSERTIONS
    // a frame-closing sample hands control to the mixing loop
    a_start_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        status.start |=> !req.ready)
        else $error("request channel still ready after a frame started mixing");

    // a new result only appears out of the emit step
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(step == STEP_EMIT))
        else $error("result valid rose outside the emit step");

    // the row index stays inside the output count while products are read
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step == STEP_READ) |-> !status.rows_done)
        else $error("coefficient read past the last output channel");
`endif

endmodule

`default_nettype wire
